@@ hdl/lssfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lssfp_pkg
// Shared widths, constants, state encoding and saturation helpers for the
// full-pivot linear system solver.
// ----------------------------------------------------------------------------
package lssfp_pkg;

  localparam int MAX_N_DEF  = 8;
  localparam int FRAC_DEF   = 16;

  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 3;
  localparam int SIZE_W     = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // clamped quotient width: magnitude up to 2^33 plus sign
  localparam int QW         = 35;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [5:0] {
    S_IDLE, S_COPY, S_COPY_END, S_ORD,
    S_SRCH, S_SRCH_END, S_PIV_CHK, S_COL_CHK,
    S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
    S_PIV_RD, S_PIV_GET, S_DET_UPD,
    S_ELI_ROW, S_ELI_FAC, S_ELI_AKJ, S_ELI_AIJ, S_ELI_DIV, S_ELI_RKJ,
    S_NEXT_K, S_SING,
    S_BK_ROW, S_BK_RA, S_BK_RX, S_BK_MUL, S_BK_ACC,
    S_BK_RB, S_BK_GB, S_BK_DS, S_BK_DW,
    S_SM_RO, S_SM_RX, S_SM_WR,
    S_OUT_RD, S_OUT_LD, S_OUT_WT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic sat_hit(input logic signed [63:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return a * b;
  endfunction

endpackage

@@ hdl/lssfp_if.sv @@
// ----------------------------------------------------------------------------
// lssfp channel interfaces
// Valid/ready channels for matrix elements, results and the size register.
// ----------------------------------------------------------------------------
interface lssfp_src_if;
  import lssfp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic signed [VAL_W-1:0] value;
  logic                    last;
  modport source (output valid, row, col, value, last, input ready);
  modport sink   (input valid, row, col, value, last, output ready);
endinterface

interface lssfp_res_if;
  import lssfp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value_res;
  logic                    singular;
  logic                    overflow;
  logic                    last_result;
  modport source (output valid, kind, index, value_res, singular, overflow, last_result,
                  input ready);
  modport sink   (input valid, kind, index, value_res, singular, overflow, last_result,
                  output ready);
endinterface

interface lssfp_cfg_if;
  import lssfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/lssfp_div.sv @@
// ----------------------------------------------------------------------------
// lssfp_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. The quotient is clamped to +/-2^33, enough to decide saturation.
// ----------------------------------------------------------------------------
module lssfp_div #(
  parameter int NUMW = 64 + lssfp_pkg::FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [NUMW-1:0]         num,
  input  logic signed [31:0]             den,
  output logic                           done,
  output logic signed [lssfp_pkg::QW-1:0] q
);
  import lssfp_pkg::*;

  localparam int CW = $clog2(NUMW + 1);

  logic [NUMW-1:0] quo;
  logic [31:0]     rem;
  logic [31:0]     dmag;
  logic            neg;
  logic            busy;
  logic [CW-1:0]   cnt;

  logic [32:0]     r2;
  logic            ge;
  logic [31:0]     rem_next;
  logic            big;
  logic [QW-1:0]   qm;

  always_comb begin
    r2       = {rem, quo[NUMW-1]};
    ge       = r2 >= {1'b0, dmag};
    rem_next = ge ? 32'(r2 - {1'b0, dmag}) : r2[31:0];
    big      = quo >= (NUMW'(1) << (QW - 2));
    qm       = big ? (QW'(1) << (QW - 2)) : {2'b00, quo[QW-3:0]};
    q        = neg ? -$signed(qm) : $signed(qm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        dmag <= den[31] ? 32'(-den) : 32'(den);
        neg  <= num[NUMW-1] ^ den[31];
        rem  <= '0;
        cnt  <= CW'(NUMW);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NUMW-2:0], ge};
        rem <= rem_next;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/linear_system_solver_full_pivot.sv @@
// ----------------------------------------------------------------------------
// linear_system_solver_full_pivot
// Gaussian elimination with full pivoting over a loaded augmented matrix.
// ----------------------------------------------------------------------------
// Elements of [A | b] load at one item per cycle into a store memory; the
// item marked last starts a solve, during which no element is taken. The
// solve copies the store into a working memory, sets up the column order,
// then per step scans the remaining submatrix for the pivot (one entry a
// cycle), swaps rows and columns element by element (read both, write
// both), and updates every element below and right of the pivot. Each
// update and each back-substitution step runs through one shared divider,
// which dominates the cost of a solve. Results leave one per accepted
// handshake, N solution values in variable order then the determinant;
// each result is read and loaded before it is offered.
module linear_system_solver_full_pivot #(
  parameter int FRAC_BITS = lssfp_pkg::FRAC_DEF
) (
  input logic        clk,
  input logic        rst,
  lssfp_src_if.sink   src,
  lssfp_res_if.source res,
  lssfp_cfg_if.sink   cfg
);
  import lssfp_pkg::*;

  localparam int MAX_N    = MAX_N_DEF;
  localparam int NCOLS    = MAX_N + 1;
  localparam int SD       = MAX_N * NCOLS;
  localparam int WD       = SD + 2 * MAX_N;
  localparam int SAW      = $clog2(SD);
  localparam int AW       = $clog2(WD);
  localparam int IW       = $clog2(MAX_N + 1);
  localparam int NUMW     = 64 + FRAC_BITS;
  localparam int ORD_BASE = SD;
  localparam int SOL_BASE = SD + MAX_N;
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * NCOLS + int'(c));
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // truncating division by 2^FRAC_BITS
  function automatic logic signed [63:0] tdiv_one(input logic signed [63:0] x);
    logic signed [63:0] adj;
    adj = x + (x[63] ? (ONE64 - 64'sd1) : 64'sd0);
    return adj >>> FRAC_BITS;
  endfunction

  // memories
  logic signed [31:0] store_mem [SD];
  logic signed [31:0] work_mem  [WD];
  logic signed [31:0] store_rdata;
  logic signed [31:0] rdata;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;

  state_t state, state_next;

  logic [SIZE_W-1:0]  size;
  logic [IW-1:0]      n, nm1, n_clamp;
  logic [IW-1:0]      k, i, j, v, sw_c, bi, bj, ordv;
  logic [IW-1:0]      sr_i, sr_j;
  logic               sr_v, sr_first;
  logic [SAW-1:0]     p, cp_a;
  logic               cp_v;
  logic               sw_col;
  logic [31:0]        best;
  logic signed [31:0] det, piv, fac, aij, tmp;
  logic signed [63:0] prod, sum, bnum;
  logic               sing, ovf;

  logic               out_kind, out_sing, out_ovf, out_last;
  logic [IDX_W-1:0]   out_index;
  logic signed [31:0] out_value;

  logic               div_start, div_done;
  logic signed [NUMW-1:0] div_num;
  logic signed [31:0] div_den;
  logic signed [QW-1:0] div_q;

  logic [AW-1:0]      sw_a, sw_b;
  logic signed [63:0] sat_in;
  logic               sat_en;
  logic signed [31:0] sat_val;
  logic               src_in_range;

  lssfp_div #(.NUMW(NUMW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign src.ready   = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign res.valid   = (state == S_OUT_WT);
  assign res.kind        = out_kind;
  assign res.index       = out_index;
  assign res.value_res   = out_value;
  assign res.singular    = out_sing;
  assign res.overflow    = out_ovf;
  assign res.last_result = out_last;

  assign nm1 = n - IW'(1);
  assign src_in_range = (int'(src.row) < MAX_N) && (int'(src.col) <= MAX_N);
  assign sat_val = sat32(sat_in);

  always_comb begin
    if (size == '0) n_clamp = IW'(1);
    else if (int'(size) > MAX_N) n_clamp = IW'(MAX_N);
    else n_clamp = IW'(size);
  end

  // swap pair addresses; the column pass ends on the column order entries
  always_comb begin
    if (sw_col) begin
      sw_a = (sw_c == n) ? AW'(ORD_BASE + int'(k))  : maddr(sw_c, k);
      sw_b = (sw_c == n) ? AW'(ORD_BASE + int'(bj)) : maddr(sw_c, bj);
    end else begin
      sw_a = maddr(k, sw_c);
      sw_b = maddr(bi, sw_c);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (src.valid && src.last) state_next = S_COPY;
      S_COPY:     if (p == SAW'(SD - 1)) state_next = S_COPY_END;
      S_COPY_END: state_next = S_ORD;
      S_ORD:      if (sw_c == IW'(MAX_N - 1)) state_next = S_SRCH;
      S_SRCH:     if (i == nm1 && j == nm1) state_next = S_SRCH_END;
      S_SRCH_END: state_next = S_PIV_CHK;
      S_PIV_CHK: begin
        if (best == '0) state_next = S_SING;
        else if (bi != k) state_next = S_SW_RA;
        else state_next = S_COL_CHK;
      end
      S_COL_CHK:  state_next = (bj != k) ? S_SW_RA : S_PIV_RD;
      S_SW_RA:    state_next = S_SW_RB;
      S_SW_RB:    state_next = S_SW_WA;
      S_SW_WA:    state_next = S_SW_WB;
      S_SW_WB: begin
        if (sw_c == n) state_next = sw_col ? S_PIV_RD : S_COL_CHK;
        else state_next = S_SW_RA;
      end
      S_PIV_RD:   state_next = S_PIV_GET;
      S_PIV_GET:  state_next = S_DET_UPD;
      S_DET_UPD:  state_next = S_ELI_ROW;
      S_ELI_ROW:  state_next = (i == n) ? S_NEXT_K : S_ELI_FAC;
      S_ELI_FAC:  state_next = S_ELI_AKJ;
      S_ELI_AKJ:  state_next = S_ELI_AIJ;
      S_ELI_AIJ:  state_next = S_ELI_DIV;
      S_ELI_DIV:  if (div_done) state_next = (j == n) ? S_ELI_ROW : S_ELI_RKJ;
      S_ELI_RKJ:  state_next = S_ELI_AKJ;
      S_NEXT_K:   state_next = (k == nm1) ? S_BK_ROW : S_SRCH;
      S_SING:     state_next = S_OUT_RD;
      S_BK_ROW:   state_next = (k == nm1) ? S_BK_RB : S_BK_RA;
      S_BK_RA:    state_next = S_BK_RX;
      S_BK_RX:    state_next = S_BK_MUL;
      S_BK_MUL:   state_next = S_BK_ACC;
      S_BK_ACC:   state_next = (j == nm1) ? S_BK_RB : S_BK_RA;
      S_BK_RB:    state_next = S_BK_GB;
      S_BK_GB:    state_next = S_BK_DS;
      S_BK_DS:    state_next = S_BK_DW;
      S_BK_DW:    if (div_done) state_next = (k == '0) ? S_SM_RO : S_BK_ROW;
      S_SM_RO:    state_next = S_SM_RX;
      S_SM_RX:    state_next = S_SM_WR;
      S_SM_WR:    state_next = (k == nm1) ? S_OUT_RD : S_SM_RO;
      S_OUT_RD:   state_next = S_OUT_LD;
      S_OUT_LD:   state_next = S_OUT_WT;
      S_OUT_WT:   if (res.ready) state_next = (v == n) ? S_IDLE : S_OUT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory ports, divider start and saturation source
  always_comb begin
    rd_addr   = '0;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    div_start = 1'b0;
    div_num   = {{FRAC_BITS{prod[63]}}, prod};
    div_den   = piv;
    sat_in    = '0;
    sat_en    = 1'b0;
    unique case (state)
      S_ORD: begin
        we = 1'b1;
        wa = AW'(ORD_BASE + int'(sw_c));
        wd = 32'(sw_c);
      end
      S_SRCH:    rd_addr = maddr(i, j);
      S_PIV_CHK: begin
        sat_in = -64'(det);
        sat_en = (best != '0) && (bi != k);
      end
      S_COL_CHK: begin
        sat_in = -64'(det);
        sat_en = (bj != k);
      end
      S_SW_RA:   rd_addr = sw_a;
      S_SW_RB:   rd_addr = sw_b;
      S_SW_WA: begin
        we = 1'b1;
        wa = sw_a;
        wd = rdata;
      end
      S_SW_WB: begin
        we = 1'b1;
        wa = sw_b;
        wd = tmp;
      end
      S_PIV_RD:  rd_addr = maddr(k, k);
      S_DET_UPD: begin
        sat_in = tdiv_one(prod);
        sat_en = 1'b1;
      end
      S_ELI_ROW: rd_addr = maddr(i, k);
      S_ELI_FAC: rd_addr = maddr(k, j);
      S_ELI_AKJ: rd_addr = maddr(i, j);
      S_ELI_AIJ: div_start = 1'b1;
      S_ELI_DIV: begin
        sat_in = 64'(aij) - 64'(div_q);
        sat_en = div_done;
        we     = div_done;
        wa     = maddr(i, j);
        wd     = sat_val;
      end
      S_ELI_RKJ: rd_addr = maddr(k, j);
      S_BK_RA:   rd_addr = maddr(k, j);
      S_BK_RX:   rd_addr = maddr(j, n);
      S_BK_RB:   rd_addr = maddr(k, n);
      S_BK_GB:   rd_addr = maddr(k, k);
      S_BK_DS: begin
        div_start = 1'b1;
        div_num   = {bnum, {FRAC_BITS{1'b0}}};
        div_den   = rdata;
      end
      S_BK_DW: begin
        sat_in = 64'(div_q);
        sat_en = div_done;
        we     = div_done;
        wa     = maddr(k, n);
        wd     = sat_val;
      end
      S_SM_RO:   rd_addr = AW'(ORD_BASE + int'(k));
      S_SM_RX:   rd_addr = maddr(k, n);
      S_SM_WR: begin
        we = 1'b1;
        wa = AW'(SOL_BASE + int'(ordv));
        wd = rdata;
      end
      S_OUT_RD:  rd_addr = (v == n) ? '0 : AW'(SOL_BASE + int'(v));
      default: ;
    endcase
    // store to working copy, in the cycle after the store read
    if (cp_v) begin
      we = 1'b1;
      wa = AW'(cp_a);
      wd = store_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready && src_in_range)
      store_mem[SAW'(int'(src.row) * NCOLS + int'(src.col))] <= src.value;
    store_rdata <= store_mem[p];
  end

  always_ff @(posedge clk) begin
    if (we) work_mem[wa] <= wd;
    rdata <= work_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size  <= SIZE_RESET;
      det   <= ONE32;
      sing  <= 1'b0;
      ovf   <= 1'b0;
      cp_v  <= 1'b0;
      sr_v  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) size <= cfg.data;
      cp_v     <= (state == S_COPY);
      cp_a     <= p;
      sr_v     <= (state == S_SRCH);
      sr_i     <= i;
      sr_j     <= j;
      sr_first <= (state == S_SRCH) && (i == k) && (j == k);
      // strict compare keeps the first maximum in row-major order
      if (sr_v && (sr_first || mag32(rdata) > best)) begin
        best <= mag32(rdata);
        bi   <= sr_i;
        bj   <= sr_j;
      end
      if (sat_en) ovf <= ovf | sat_hit(sat_in);

      unique case (state)
        S_IDLE: begin
          if (src.valid && src.last) begin
            n    <= n_clamp;
            p    <= '0;
            det  <= ONE32;
            sing <= 1'b0;
            ovf  <= 1'b0;
            sw_c <= '0;
          end
        end
        S_COPY: p <= p + SAW'(1);
        S_ORD: begin
          sw_c <= sw_c + IW'(1);
          k    <= '0;
          i    <= '0;
          j    <= '0;
        end
        S_SRCH: begin
          if (j == nm1) begin
            j <= k;
            i <= i + IW'(1);
          end else begin
            j <= j + IW'(1);
          end
        end
        S_PIV_CHK: begin
          if (best != '0 && bi != k) begin
            det    <= sat_val;
            sw_col <= 1'b0;
            sw_c   <= '0;
          end
        end
        S_COL_CHK: begin
          if (bj != k) begin
            det    <= sat_val;
            sw_col <= 1'b1;
            sw_c   <= '0;
          end
        end
        S_SW_RB: tmp <= rdata;
        S_SW_WB: sw_c <= sw_c + IW'(1);
        S_PIV_GET: begin
          piv  <= rdata;
          prod <= mul32(det, rdata);
        end
        S_DET_UPD: begin
          det <= sat_val;
          i   <= k + IW'(1);
        end
        S_ELI_ROW: j <= k + IW'(1);
        S_ELI_FAC: fac <= rdata;
        S_ELI_AKJ: prod <= mul32(fac, rdata);
        S_ELI_AIJ: aij <= rdata;
        S_ELI_DIV: begin
          if (div_done) begin
            if (j == n) i <= i + IW'(1);
            else j <= j + IW'(1);
          end
        end
        S_NEXT_K: begin
          if (k != nm1) begin
            k <= k + IW'(1);
            i <= k + IW'(1);
            j <= k + IW'(1);
          end
        end
        S_SING: begin
          sing <= 1'b1;
          det  <= '0;
          v    <= '0;
        end
        S_BK_ROW: begin
          sum <= '0;
          j   <= k + IW'(1);
        end
        S_BK_RX:  fac <= rdata;
        S_BK_MUL: prod <= mul32(fac, rdata);
        S_BK_ACC: begin
          sum <= sum + tdiv_one(prod);
          j   <= j + IW'(1);
        end
        S_BK_GB: bnum <= 64'(rdata) - sum;
        S_BK_DW: if (div_done && k != '0) k <= k - IW'(1);
        S_SM_RX: ordv <= rdata[IW-1:0];
        S_SM_WR: begin
          if (k == nm1) v <= '0;
          else k <= k + IW'(1);
        end
        S_OUT_LD: begin
          out_kind  <= (v == n);
          out_index <= (v == n) ? '0 : IDX_W'(v);
          out_value <= (v == n) ? det : (sing ? 32'sd0 : rdata);
          out_sing  <= sing;
          out_ovf   <= ovf;
          out_last  <= (v == n);
        end
        S_OUT_WT: if (res.ready && v != n) v <= v + IW'(1);
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/lssfp_chk.sv @@
// ----------------------------------------------------------------------------
// lssfp_chk
// Port-level checks for the full-pivot solver, bound to the top level.
// ----------------------------------------------------------------------------
module lssfp_chk (
  input logic        clk,
  input logic        rst,
  input logic        src_valid,
  input logic        src_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic [2:0]  index,
  input logic [31:0] value_res,
  input logic        singular,
  input logic        last_result
);

  // a result waiting for its sink holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(value_res))
    else $error("result changed while stalled");

  // no element is taken while results of a solve are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(src_ready && res_valid))
    else $error("input taken during result delivery");

  // the determinant is the last item of a run and carries index zero
  a_det_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind != last_result) |-> 1'b0)
    else $error("determinant and last item disagree");

  a_det_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind |-> index == 3'd0)
    else $error("determinant with nonzero index");

  // a singular system gives zero solution values
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && singular && !kind |-> value_res == 32'd0)
    else $error("nonzero solution on singular system");

endmodule

bind linear_system_solver_full_pivot lssfp_chk u_lssfp_chk (
  .clk         (clk),
  .rst         (rst),
  .src_valid   (src.valid),
  .src_ready   (src.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .kind        (res.kind),
  .index       (res.index),
  .value_res   (res.value_res),
  .singular    (res.singular),
  .last_result (res.last_result)
);
